### sv/rmq_pkg.sv
// types and constants shared by the rotation matrix to quaternion pipeline
// no dependencies
package rmq_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned DiffW = 33;
  localparam int unsigned RadW  = 35;
  localparam int unsigned RootW = 32;
  localparam int unsigned NumW  = 64;
  localparam int unsigned LaneN = 3;

  typedef enum logic [1:0] {
    LEAD_X = 2'd0,
    LEAD_Y = 2'd1,
    LEAD_Z = 2'd2,
    LEAD_W = 2'd3
  } lead_e;

  // lanes hold the three non-leading components in ascending order x, y, z, w
  typedef struct packed {
    lead_e                    lead;
    logic signed [DiffW-1:0]  d2;
    logic signed [DiffW-1:0]  d1;
    logic signed [DiffW-1:0]  d0;
  } sq_sb_t;

endpackage

### sv/rotation_matrix_to_quaternion_core.sv
// rotation matrix to quaternion conversion, fully pipelined
// depends on rmq_pkg, rmq_front, rmq_sqrt, rmq_div
//
// usage:
//   s_axis carries one 3x3 rotation matrix per word (nine signed Q2.30
//   entries), m_axis carries one quaternion x, y, z, w per word.
//   the root of the chosen radicand is taken one bit per stage and the
//   three remaining components are divided one quotient bit per stage.
//   one word is accepted per cycle while m_axis is taking results.
//   throughput is set by the shared pipeline enable: all stages advance
//   together, so a stall on m_axis_tready freezes the whole pipeline and
//   drops s_axis_tready; nothing is lost or repeated.
//   s_axis_tready is high whenever the output register is empty or being
//   read, so a finished result that is not taken holds off new words.
//   reset clears every valid bit; no result is shown until a word arrives.
//   a lane saturates where the root is zero or it overflows, unless it is zero.
module rotation_matrix_to_quaternion_core import rmq_pkg::*; #(
  parameter int unsigned FRAC_BITS = 30
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // m00, m01, m02, m10, m11, m12, m20, m21, m22 (32 bits each, lowest first)
  input  logic [287:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // quat_x, quat_y, quat_z, quat_w (32 bits each, lowest first)
  output logic [127:0] m_axis_tdata
);

  logic            en;
  logic            fr_vld, sq_vld, dv_vld;
  logic [NumW-1:0] fr_rad;
  sq_sb_t          fr_sb, sq_sb;
  logic [RootW-1:0] sq_root;
  lead_e           dv_lead;
  logic signed [DataW-1:0] dv_lead_val;
  logic            dv_szero;
  logic signed [DataW-1:0] dv_lane [LaneN];
  logic signed [DataW-1:0] qx_d, qy_d, qz_d, qw_d;
  logic [127:0]    out_q;
  logic            out_vld_q;
  lead_e           out_lead_q;

  assign en = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;

  rmq_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk_i, .rst_ni, .en_i(en), .vld_i(s_axis_tvalid),
    .m00_i(s_axis_tdata[31:0]),    .m01_i(s_axis_tdata[63:32]),
    .m02_i(s_axis_tdata[95:64]),   .m10_i(s_axis_tdata[127:96]),
    .m11_i(s_axis_tdata[159:128]), .m12_i(s_axis_tdata[191:160]),
    .m20_i(s_axis_tdata[223:192]), .m21_i(s_axis_tdata[255:224]),
    .m22_i(s_axis_tdata[287:256]),
    .vld_o(fr_vld), .rad_o(fr_rad), .sb_o(fr_sb)
  );

  rmq_sqrt u_sqrt (
    .clk_i, .rst_ni, .en_i(en), .vld_i(fr_vld), .n_i(fr_rad), .sb_i(fr_sb),
    .vld_o(sq_vld), .root_o(sq_root), .sb_o(sq_sb)
  );

  rmq_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk_i, .rst_ni, .en_i(en), .vld_i(sq_vld), .root_i(sq_root), .sb_i(sq_sb),
    .vld_o(dv_vld), .lead_o(dv_lead), .lead_val_o(dv_lead_val),
    .root_zero_o(dv_szero), .lane_o(dv_lane)
  );

  // put the leading component in its slot, the lanes fill the rest in order
  always_comb begin
    case (dv_lead)
      LEAD_X: begin
        qx_d = dv_lead_val; qy_d = dv_lane[0]; qz_d = dv_lane[1]; qw_d = dv_lane[2];
      end
      LEAD_Y: begin
        qx_d = dv_lane[0]; qy_d = dv_lead_val; qz_d = dv_lane[1]; qw_d = dv_lane[2];
      end
      LEAD_Z: begin
        qx_d = dv_lane[0]; qy_d = dv_lane[1]; qz_d = dv_lead_val; qw_d = dv_lane[2];
      end
      default: begin
        qx_d = dv_lane[0]; qy_d = dv_lane[1]; qz_d = dv_lane[2]; qw_d = dv_lead_val;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      out_lead_q <= LEAD_W;
    end else if (en) begin
      out_vld_q  <= dv_vld;
      out_lead_q <= dv_lead;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) out_q <= {qw_d, qz_d, qy_d, qx_d};
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

`ifndef ASSERT_OFF
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without an output stall");
  a_lead_w_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && out_lead_q == LEAD_W) |-> !m_axis_tdata[127])
    else $error("leading w component negative");
  a_zero_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dv_vld && dv_szero) |-> (dv_lead_val == '0))
    else $error("zero root gave nonzero leading component");
`endif

endmodule

### sv/rmq_front.sv
// front end: trace, branch choice, radicand and off-diagonal terms, two stages
// depends on rmq_pkg
module rmq_front import rmq_pkg::*; #(
  parameter int unsigned FRAC_BITS = 30
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    vld_i,
  input  logic signed [DataW-1:0] m00_i,
  input  logic signed [DataW-1:0] m01_i,
  input  logic signed [DataW-1:0] m02_i,
  input  logic signed [DataW-1:0] m10_i,
  input  logic signed [DataW-1:0] m11_i,
  input  logic signed [DataW-1:0] m12_i,
  input  logic signed [DataW-1:0] m20_i,
  input  logic signed [DataW-1:0] m21_i,
  input  logic signed [DataW-1:0] m22_i,
  output logic                    vld_o,
  output logic [NumW-1:0]         rad_o,
  output sq_sb_t                  sb_o
);

  logic signed [RadW-1:0] one;
  logic signed [RadW-1:0] tr, rw, rx, ry, rz;
  lead_e                  lead_d, lead_q;
  logic signed [RadW-1:0] rad_d, rad_q;
  logic signed [DiffW-1:0] a_d, b_d, c_d, p_d, s_d, r_d;
  logic signed [DiffW-1:0] a_q, b_q, c_q, p_q, s_q, r_q;
  logic                   vld1_q, vld2_q;
  logic [NumW-1:0]        n_d, n_q;
  sq_sb_t                 sb_d, sb_q;

  assign one = RadW'(1) <<< FRAC_BITS;

  always_comb begin
    tr = RadW'(m00_i) + RadW'(m11_i) + RadW'(m22_i);
    rw = tr + one;
    rx = RadW'(m00_i) - RadW'(m11_i) - RadW'(m22_i) + one;
    ry = RadW'(m11_i) - RadW'(m22_i) - RadW'(m00_i) + one;
    rz = RadW'(m22_i) - RadW'(m00_i) - RadW'(m11_i) + one;
    a_d = DiffW'(m21_i) - DiffW'(m12_i);
    b_d = DiffW'(m02_i) - DiffW'(m20_i);
    c_d = DiffW'(m10_i) - DiffW'(m01_i);
    p_d = DiffW'(m01_i) + DiffW'(m10_i);
    s_d = DiffW'(m20_i) + DiffW'(m02_i);
    r_d = DiffW'(m12_i) + DiffW'(m21_i);
    // ties keep the earlier diagonal entry
    if (!tr[RadW-1]) begin
      lead_d = LEAD_W;
      rad_d  = rw;
    end else if (m22_i > ((m11_i > m00_i) ? m11_i : m00_i)) begin
      lead_d = LEAD_Z;
      rad_d  = rz;
    end else if (m11_i > m00_i) begin
      lead_d = LEAD_Y;
      rad_d  = ry;
    end else begin
      lead_d = LEAD_X;
      rad_d  = rx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      lead_q <= LEAD_W;
    end else if (en_i) begin
      vld1_q <= vld_i;
      vld2_q <= vld1_q;
      lead_q <= lead_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_q <= rad_d;
      a_q <= a_d; b_q <= b_d; c_q <= c_d;
      p_q <= p_d; s_q <= s_d; r_q <= r_d;
      n_q <= n_d;
      sb_q <= sb_d;
    end
  end

  always_comb begin
    // negative radicand counts as zero
    if (rad_q[RadW-1] || rad_q == '0) n_d = '0;
    else n_d = NumW'(rad_q) << FRAC_BITS;
    sb_d.lead = lead_q;
    case (lead_q)
      LEAD_X: begin
        sb_d.d0 = p_q; sb_d.d1 = s_q; sb_d.d2 = a_q;
      end
      LEAD_Y: begin
        sb_d.d0 = p_q; sb_d.d1 = r_q; sb_d.d2 = b_q;
      end
      LEAD_Z: begin
        sb_d.d0 = s_q; sb_d.d1 = r_q; sb_d.d2 = c_q;
      end
      default: begin
        sb_d.d0 = a_q; sb_d.d1 = b_q; sb_d.d2 = c_q;
      end
    endcase
  end

  assign vld_o = vld2_q;
  assign rad_o = n_q;
  assign sb_o  = sb_q;

endmodule

### sv/rmq_sqrt.sv
// pipelined integer square root, one root bit per stage, sideband carried along
// depends on rmq_pkg
module rmq_sqrt import rmq_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             vld_i,
  input  logic [NumW-1:0]  n_i,
  input  sq_sb_t           sb_i,
  output logic             vld_o,
  output logic [RootW-1:0] root_o,
  output sq_sb_t           sb_o
);

  localparam int unsigned RemW = RootW + 4;

  logic [RemW-1:0]  rem [RootW+1];
  logic [RootW-1:0] res [RootW+1];
  logic [NumW-1:0]  nn  [RootW+1];
  sq_sb_t           sb  [RootW+1];
  logic             vld [RootW+1];

  assign rem[0] = '0;
  assign res[0] = '0;
  assign nn[0]  = n_i;
  assign sb[0]  = sb_i;
  assign vld[0] = vld_i;

  for (genvar i = 0; i < RootW; i++) begin : g_stage
    logic [RemW-1:0]  rem_t, trial, rem_d;
    logic [RootW-1:0] res_d;

    always_comb begin
      rem_t = {rem[i][RemW-3:0], nn[i][NumW-1 -: 2]};
      trial = RemW'({res[i], 2'b01});
      if (rem_t >= trial) begin
        rem_d = rem_t - trial;
        res_d = {res[i][RootW-2:0], 1'b1};
      end else begin
        rem_d = rem_t;
        res_d = {res[i][RootW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) vld[i+1] <= 1'b0;
      else if (en_i) vld[i+1] <= vld[i];
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem[i+1] <= rem_d;
        res[i+1] <= res_d;
        nn[i+1]  <= {nn[i][NumW-3:0], 2'b00};
        sb[i+1]  <= sb[i];
      end
    end
  end

  assign vld_o  = vld[RootW];
  assign root_o = res[RootW];
  assign sb_o   = sb[RootW];

endmodule

### sv/rmq_div.sv
// three-lane pipelined restoring divider for d*0.5/root with saturation,
// plus the leading component; depends on rmq_pkg
module rmq_div import rmq_pkg::*; #(
  parameter int unsigned FRAC_BITS = 30
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    vld_i,
  input  logic [RootW-1:0]        root_i,
  input  sq_sb_t                  sb_i,
  output logic                    vld_o,
  output lead_e                   lead_o,
  output logic signed [DataW-1:0] lead_val_o,
  output logic                    root_zero_o,
  output logic signed [DataW-1:0] lane_o [LaneN]
);

  localparam int unsigned QW   = 32;
  localparam int unsigned DenW = RootW + 1;
  localparam int unsigned RemW = DenW + 1;

  typedef struct packed {
    lead_e                   lead;
    logic signed [DataW-1:0] lead_val;
    logic                    szero;
  } dv_sb_t;

  typedef struct packed {
    logic neg;
    logic zero;
    logic big;
  } lane_fl_t;

  logic           vld [QW+1];
  dv_sb_t         sb  [QW+1];
  logic [DenW-1:0] den [QW+1];

  logic [RootW:0] half;
  logic [DiffW-1:0] d_arr [LaneN];

  assign d_arr[0] = sb_i.d0;
  assign d_arr[1] = sb_i.d1;
  assign d_arr[2] = sb_i.d2;
  assign half = ({1'b0, root_i} + (RootW+1)'(1)) >> 1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld[0] <= 1'b0;
    else if (en_i) vld[0] <= vld_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sb[0].lead     <= sb_i.lead;
      sb[0].lead_val <= half[RootW] ? DataW'(32'h7FFF_FFFF) : DataW'(half[RootW-1:0]);
      sb[0].szero    <= (root_i == '0);
      den[0]         <= {root_i, 1'b0};
    end
  end

  for (genvar i = 0; i < QW; i++) begin : g_ctl
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) vld[i+1] <= 1'b0;
      else if (en_i) vld[i+1] <= vld[i];
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sb[i+1]  <= sb[i];
        den[i+1] <= den[i];
      end
    end
  end

  for (genvar l = 0; l < LaneN; l++) begin : g_lane
    logic [RemW-1:0] rem [QW+1];
    logic [QW-1:0]   lo  [QW+1];
    logic [QW-1:0]   q   [QW+1];
    lane_fl_t        fl  [QW+1];
    logic [DiffW-1:0] mag;
    logic [NumW-1:0]  num;
    logic [NumW:0]    lim;

    always_comb begin
      mag = d_arr[l][DiffW-1] ? (DiffW'(0) - d_arr[l]) : d_arr[l];
      num = (NumW'(mag) << FRAC_BITS) + NumW'(root_i);
      lim = {root_i, 1'b0, QW'(0)};
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem[0]     <= RemW'(num[NumW-1:QW]);
        lo[0]      <= num[QW-1:0];
        q[0]       <= '0;
        fl[0].neg  <= d_arr[l][DiffW-1];
        fl[0].zero <= (d_arr[l] == '0);
        fl[0].big  <= ({1'b0, num} >= lim);
      end
    end

    for (genvar i = 0; i < QW; i++) begin : g_step
      logic [RemW-1:0] rem_t;
      always_comb rem_t = {rem[i][RemW-2:0], lo[i][QW-1]};
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          if (rem_t >= RemW'(den[i])) begin
            rem[i+1] <= rem_t - RemW'(den[i]);
            q[i+1]   <= {q[i][QW-2:0], 1'b1};
          end else begin
            rem[i+1] <= rem_t;
            q[i+1]   <= {q[i][QW-2:0], 1'b0};
          end
          lo[i+1] <= {lo[i][QW-2:0], 1'b0};
          fl[i+1] <= fl[i];
        end
      end
    end

    always_comb begin
      if (fl[QW].zero) lane_o[l] = '0;
      else if (fl[QW].neg) begin
        if (sb[QW].szero || fl[QW].big || q[QW] > 32'h8000_0000) lane_o[l] = 32'sh8000_0000;
        else lane_o[l] = DataW'(32'd0 - q[QW]);
      end else begin
        if (sb[QW].szero || fl[QW].big || q[QW][QW-1]) lane_o[l] = 32'sh7FFF_FFFF;
        else lane_o[l] = DataW'(q[QW]);
      end
    end
  end

  assign vld_o       = vld[QW];
  assign lead_o      = sb[QW].lead;
  assign lead_val_o  = sb[QW].szero ? '0 : sb[QW].lead_val;
  assign root_zero_o = sb[QW].szero;

endmodule
